@@ rtl/core/lps_pkg.sv @@
// shared types and constants for the lexicographic permutation stepper
package lps_pkg;

    localparam int MAX_LENGTH    = 16;
    localparam int ELEMENT_WIDTH = 8;

    // memory address and effective length widths
    localparam int AW  = $clog2(MAX_LENGTH);
    localparam int N_W = $clog2(MAX_LENGTH + 1);

    // fixed field widths
    localparam int LEN_W   = 5;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 8;
    localparam int POS_W   = 4;
    localparam int ELEM_W  = 8;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd16;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              advanced;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_P,
        ST_SCAN_S,
        ST_SWAP_RD,
        ST_SWAP_WA,
        ST_SWAP_WB,
        ST_EMIT_PRE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_SCAN_P,
        DP_FOUND_P,
        DP_SCAN_S,
        DP_FOUND_S,
        DP_SWAP_RD,
        DP_SWAP_WA,
        DP_SWAP_WB,
        DP_EMIT_PRE,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic short_len;   // fewer than two elements in use
        logic pivot_hit;   // ascent seen at the tagged pair
        logic pivot_none;  // scan reached the front with no ascent
        logic succ_hit;    // rightmost element above the pivot seen
        logic more_pairs;  // suffix reversal not finished
        logic slot_free;   // output register can take an element
        logic emit_last;   // element being emitted is the final one
    } dp_status_t;

endpackage

@@ rtl/core/lps_datapath.sv @@
// arrangement memory, scan pointers, swap registers and output register
module lps_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lps_pkg::dp_cmd_t     cmd,
    output lps_pkg::dp_status_t  status,
    input  lps_pkg::in_item_t    item,
    input  logic                 cfg_we,
    input  logic [lps_pkg::LEN_W-1:0] cfg_data,
    output lps_pkg::out_item_t   result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    localparam int AW = lps_pkg::AW;
    localparam int EW = lps_pkg::ELEMENT_WIDTH;
    localparam int NW = lps_pkg::N_W;

    logic [EW-1:0]              mem_reg [lps_pkg::MAX_LENGTH];
    logic [EW-1:0]              rda_reg;
    logic [EW-1:0]              rdb_reg;
    logic [lps_pkg::LEN_W-1:0]  len_reg;
    logic [NW-1:0]              n_reg;
    logic [AW-1:0]              j_reg;
    logic [AW-1:0]              tag_reg;
    logic                       tvalid_reg;
    logic [EW-1:0]              piv_reg;
    logic [AW-1:0]              xa_reg;
    logic [AW-1:0]              ya_reg;
    logic [AW-1:0]              lo_reg;
    logic [AW-1:0]              hi_reg;
    logic [AW-1:0]              k_reg;
    logic                       adv_reg;
    lps_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    logic [NW-1:0] eff_n;
    logic [AW-1:0] eff_last;
    logic [AW-1:0] n_last;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          pair_lt;

    // effective length: zero counts as one, saturate at the memory depth
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_n = NW'(1);
        end
        else if (32'(len_reg) > lps_pkg::MAX_LENGTH)
        begin
            eff_n = NW'(lps_pkg::MAX_LENGTH);
        end
        else
        begin
            eff_n = NW'(len_reg);
        end
    end

    assign eff_last = AW'(eff_n - NW'(1));
    assign n_last   = AW'(n_reg - NW'(1));
    assign pair_lt  = rda_reg < rdb_reg;

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        case (cmd.op)
            lps_pkg::DP_LOAD:
            begin
                wr_en   = 32'(item.index) < lps_pkg::MAX_LENGTH;
                wr_addr = AW'(item.index);
                wr_data = EW'(item.value);
            end
            lps_pkg::DP_SCAN_P:
            begin
                rd_en     = 1'b1;
                rd_addr_a = j_reg - AW'(1);
                rd_addr_b = j_reg;
            end
            lps_pkg::DP_SCAN_S:
            begin
                rd_en     = 1'b1;
                rd_addr_a = j_reg;
            end
            lps_pkg::DP_SWAP_RD:
            begin
                rd_en     = 1'b1;
                rd_addr_a = xa_reg;
                rd_addr_b = ya_reg;
            end
            lps_pkg::DP_SWAP_WA:
            begin
                wr_en   = 1'b1;
                wr_addr = xa_reg;
                wr_data = rdb_reg;
            end
            lps_pkg::DP_SWAP_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = ya_reg;
                wr_data = rda_reg;
            end
            lps_pkg::DP_EMIT_PRE:
            begin
                rd_en     = 1'b1;
                rd_addr_a = '0;
            end
            lps_pkg::DP_EMIT:
            begin
                rd_en     = 1'b1;
                rd_addr_a = k_reg + AW'(1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // arrangement memory, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rda_reg <= mem_reg[rd_addr_a];
            rdb_reg <= mem_reg[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= lps_pkg::LENGTH_RESET;
            tvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            case (cmd.op)
                lps_pkg::DP_START,
                lps_pkg::DP_FOUND_P,
                lps_pkg::DP_FOUND_S:  tvalid_reg <= 1'b0;
                lps_pkg::DP_SCAN_P,
                lps_pkg::DP_SCAN_S:   tvalid_reg <= 1'b1;
                default:              tvalid_reg <= tvalid_reg;
            endcase
            if (cmd.op == lps_pkg::DP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pointers and payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lps_pkg::DP_START:
            begin
                n_reg   <= eff_n;
                j_reg   <= eff_last;
                adv_reg <= 1'b0;
            end
            lps_pkg::DP_SCAN_P:
            begin
                tag_reg <= j_reg;
                if (j_reg > AW'(1))
                begin
                    j_reg <= j_reg - AW'(1);
                end
            end
            lps_pkg::DP_FOUND_P:
            begin
                xa_reg  <= tag_reg - AW'(1);
                piv_reg <= rda_reg;
                lo_reg  <= tag_reg;
                hi_reg  <= n_last;
                j_reg   <= n_last;
                adv_reg <= 1'b1;
            end
            lps_pkg::DP_SCAN_S:
            begin
                tag_reg <= j_reg;
                if (j_reg > lo_reg)
                begin
                    j_reg <= j_reg - AW'(1);
                end
            end
            lps_pkg::DP_FOUND_S:
            begin
                ya_reg <= tag_reg;
            end
            lps_pkg::DP_SWAP_WB:
            begin
                // next pair of the suffix reversal
                xa_reg <= lo_reg;
                ya_reg <= hi_reg;
                lo_reg <= lo_reg + AW'(1);
                hi_reg <= hi_reg - AW'(1);
            end
            lps_pkg::DP_EMIT_PRE:
            begin
                k_reg <= '0;
            end
            lps_pkg::DP_EMIT:
            begin
                out_reg.position <= lps_pkg::POS_W'(k_reg);
                out_reg.element  <= lps_pkg::ELEM_W'(rda_reg);
                out_reg.last     <= k_reg == n_last;
                out_reg.advanced <= adv_reg;
                k_reg            <= k_reg + AW'(1);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    always_comb
    begin
        status.short_len  = eff_n < NW'(2);
        status.pivot_hit  = tvalid_reg && pair_lt;
        status.pivot_none = tvalid_reg && !pair_lt && (tag_reg == AW'(1));
        status.succ_hit   = tvalid_reg && ((rda_reg > piv_reg) || (tag_reg == lo_reg));
        status.more_pairs = lo_reg < hi_reg;
        status.slot_free  = !out_valid_reg || result_ready;
        status.emit_last  = k_reg == n_last;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // elements leave in position order within a run
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lps_pkg::DP_EMIT && k_reg != '0)
        |-> (k_reg == AW'(out_reg.position) + AW'(1)))
        else $error("emitted position does not follow the previous one");

    // every swap exchanges a lower position with a strictly higher one
    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lps_pkg::DP_SWAP_RD) |-> (xa_reg < ya_reg))
        else $error("swap pair out of order");

endmodule

@@ rtl/core/lps_ctrl.sv @@
// sequencing state machine for scan, swap, reversal and emission
module lps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_op,
    output logic                item_ready,
    input  lps_pkg::dp_status_t status,
    output lps_pkg::dp_cmd_t    cmd
);

    lps_pkg::state_t state_reg;
    lps_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                if (item_valid && item_op == lps_pkg::OP_ADVANCE)
                begin
                    state_next = status.short_len ? lps_pkg::ST_EMIT_PRE : lps_pkg::ST_SCAN_P;
                end
            end
            lps_pkg::ST_SCAN_P:
            begin
                if (status.pivot_hit)
                begin
                    state_next = lps_pkg::ST_SCAN_S;
                end
                else if (status.pivot_none)
                begin
                    state_next = lps_pkg::ST_EMIT_PRE;
                end
            end
            lps_pkg::ST_SCAN_S:
            begin
                if (status.succ_hit)
                begin
                    state_next = lps_pkg::ST_SWAP_RD;
                end
            end
            lps_pkg::ST_SWAP_RD:  state_next = lps_pkg::ST_SWAP_WA;
            lps_pkg::ST_SWAP_WA:  state_next = lps_pkg::ST_SWAP_WB;
            lps_pkg::ST_SWAP_WB:
            begin
                state_next = status.more_pairs ? lps_pkg::ST_SWAP_RD : lps_pkg::ST_EMIT_PRE;
            end
            lps_pkg::ST_EMIT_PRE: state_next = lps_pkg::ST_EMIT;
            lps_pkg::ST_EMIT:
            begin
                if (status.slot_free && status.emit_last)
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            default:              state_next = lps_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op     = lps_pkg::DP_NOP;
        item_ready = 1'b0;
        case (state_reg)
            lps_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.op = (item_op == lps_pkg::OP_ADVANCE) ? lps_pkg::DP_START
                                                              : lps_pkg::DP_LOAD;
                end
            end
            lps_pkg::ST_SCAN_P:
            begin
                if (status.pivot_hit)
                begin
                    cmd.op = lps_pkg::DP_FOUND_P;
                end
                else if (!status.pivot_none)
                begin
                    cmd.op = lps_pkg::DP_SCAN_P;
                end
            end
            lps_pkg::ST_SCAN_S:
            begin
                cmd.op = status.succ_hit ? lps_pkg::DP_FOUND_S : lps_pkg::DP_SCAN_S;
            end
            lps_pkg::ST_SWAP_RD:  cmd.op = lps_pkg::DP_SWAP_RD;
            lps_pkg::ST_SWAP_WA:  cmd.op = lps_pkg::DP_SWAP_WA;
            lps_pkg::ST_SWAP_WB:  cmd.op = lps_pkg::DP_SWAP_WB;
            lps_pkg::ST_EMIT_PRE: cmd.op = lps_pkg::DP_EMIT_PRE;
            lps_pkg::ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.op = lps_pkg::DP_EMIT;
                end
            end
            default:              cmd.op = lps_pkg::DP_NOP;
        endcase
    end

    // an advance always starts a run
    a_advance_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lps_pkg::ST_IDLE && item_valid && item_op == lps_pkg::OP_ADVANCE)
        |=> (state_reg != lps_pkg::ST_IDLE))
        else $error("advance transfer did not start a run");

endmodule

@@ rtl/core/lexicographic_permutation_step.sv @@
// top level of the lexicographic permutation stepper
// an advance runs its scans and swaps one after another through the two-read,
//   one-write arrangement memory; result stalls lengthen it
// throughput: one advance at a time; results leave at one element per cycle
//   while result_ready is high
// reset: length returns to 16 and the controller to idle; the arrangement memory is
//   not cleared and holds undefined values until loaded
module lexicographic_permutation_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  lps_pkg::in_item_t          item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output lps_pkg::out_item_t         result,
    input  logic                       cfg_we,
    input  logic [lps_pkg::LEN_W-1:0]  cfg_data
);

    // command and status between the sequencer and the datapath
    lps_pkg::dp_cmd_t    cmd;
    lps_pkg::dp_status_t status;

    // sequencer: takes a transfer only when idle; a load writes one entry; an advance runs
    // pivot scan, successor scan, swap, suffix reversal (if a pivot exists) and emission
    lps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.operation),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: memory, pointers and an output register that decouples the result
    // channel, so a new item can be taken while the final element still waits
    lps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

@@ test/tb_lexicographic_permutation_step.sv @@
// self-checking testbench for the lexicographic permutation stepper
module tb_lexicographic_permutation_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 340;
    // cycles allowed for the block to settle before a length write or the end
    localparam int HOLD_OFF     = 100;
    // cycles with no transfer at all before the run is declared hung
    localparam int STALL_LIMIT  = 3000;
    // idle chance per cycle, in percent
    localparam int IDLE_PCT     = 28;

    // one row of the directed table: either a length write or one input transfer
    typedef struct {
        logic                      is_cfg;
        logic [lps_pkg::LEN_W-1:0] len;
        lps_pkg::in_item_t         it;
        logic                      held;   // typed result: already last, stays as is, advanced 0
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      item_valid = 1'b0;
    logic                      item_ready;
    lps_pkg::in_item_t         item = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    lps_pkg::out_item_t        result;
    logic                      cfg_we = 1'b0;
    logic [lps_pkg::LEN_W-1:0] cfg_data = '0;

    // long window with no idling on either side
    logic quiet = 1'b0;

    // shadow copy of the block's state
    logic [lps_pkg::ELEMENT_WIDTH-1:0] shadow_arr [lps_pkg::MAX_LENGTH];
    logic [lps_pkg::LEN_W-1:0]         shadow_len;

    lps_pkg::out_item_t expected_results [$];
    row_t               directed [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int loads_sent    = 0;
    int advances_sent = 0;
    int final_hits    = 0;
    int results_seen  = 0;
    int length_writes = 0;
    int idle_cycles   = 0;

    lexicographic_permutation_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // length in use: zero acts as one, anything past the store saturates
    function automatic int active_count();
        int n;
        n = int'(shadow_len);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > lps_pkg::MAX_LENGTH)
        begin
            n = lps_pkg::MAX_LENGTH;
        end
        return n;
    endfunction

    function automatic void swap_shadow(input int a, input int b);
        logic [lps_pkg::ELEMENT_WIDTH-1:0] t;
        t = shadow_arr[a];
        shadow_arr[a] = shadow_arr[b];
        shadow_arr[b] = t;
    endfunction

    // steps the first n entries to their successor, returns 0 when there is none
    function automatic logic advance_shadow(input int n);
        int p;
        int s;
        int lo;
        int hi;
        if (n < 2)
        begin
            return 1'b0;
        end
        // rightmost ascent marks the pivot
        p = n - 1;
        while (p > 0 && !(shadow_arr[p-1] < shadow_arr[p]))
        begin
            p--;
        end
        if (p == 0)
        begin
            return 1'b0;
        end
        p = p - 1;
        // rightmost element strictly above the pivot
        s = n - 1;
        while (s > p + 1 && shadow_arr[s] <= shadow_arr[p])
        begin
            s--;
        end
        swap_shadow(p, s);
        lo = p + 1;
        hi = n - 1;
        while (lo < hi)
        begin
            swap_shadow(lo, hi);
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // queue the whole arrangement in use as one emitted run
    function automatic void queue_run(input logic adv);
        int n;
        lps_pkg::out_item_t r;
        n = active_count();
        for (int k = 0; k < n; k++)
        begin
            r.position = k[lps_pkg::POS_W-1:0];
            r.element  = shadow_arr[k];
            r.last     = (k == n - 1);
            r.advanced = adv;
            expected_results.push_back(r);
        end
        if (!adv)
        begin
            final_hits++;
        end
    endfunction

    // drive one item from a falling edge, wait for its transfer, update the shadow
    task automatic send_item(input lps_pkg::in_item_t it, input logic held);
        logic adv;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (it.operation == lps_pkg::OP_LOAD)
        begin
            loads_sent++;
            if (it.index < lps_pkg::MAX_LENGTH)
            begin
                shadow_arr[it.index] = it.value;
            end
        end
        else
        begin
            advances_sent++;
            if (held)
            begin
                // typed expectation: arrangement already last, nothing moves
                queue_run(1'b0);
            end
            else
            begin
                adv = advance_shadow(active_count());
                queue_run(adv);
            end
        end
        quiet <= (items_sent >= 160 && items_sent < 240);
        @(negedge clk);
    endtask

    // the length register is only written with the block drained and settled
    task automatic set_length(input logic [lps_pkg::LEN_W-1:0] len);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (HOLD_OFF) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_len = len;
        length_writes++;
    endtask

    function automatic lps_pkg::in_item_t make_item(input logic op, input int idx,
                                                    input int val);
        lps_pkg::in_item_t it;
        it.operation = op;
        it.index     = idx[lps_pkg::IDX_W-1:0];
        it.value     = val[lps_pkg::VAL_W-1:0];
        return it;
    endfunction

    function automatic void add_row(input logic is_cfg, input int len,
                                    input lps_pkg::in_item_t it, input logic held);
        row_t r;
        r.is_cfg = is_cfg;
        r.len    = len[lps_pkg::LEN_W-1:0];
        r.it     = it;
        r.held   = held;
        directed.push_back(r);
    endfunction

    // mostly short arrangements, now and then zero, full or beyond the store
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 0;
        end
        else if (r < 16)
        begin
            return 1;
        end
        else if (r < 72)
        begin
            return $urandom_range(2, 5);
        end
        else if (r < 88)
        begin
            return $urandom_range(6, 16);
        end
        return $urandom_range(17, 31);
    endfunction

    // small alphabets give plenty of repeated values
    function automatic int draw_value(input int alphabet, input int n);
        case (alphabet)
            0: return $urandom_range(0, 1);
            1: return $urandom_range(0, n);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // receiver stalls at random except in the quiet window
    always @(negedge clk)
    begin
        result_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result checker: every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        lps_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result pos %0d elem %0d",
                                          result.position, result.element));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.position !== want.position)
                begin
                    report_mismatch($sformatf("position got %0d want %0d",
                                              result.position, want.position));
                end
                if (result.element !== want.element)
                begin
                    report_mismatch($sformatf("element at pos %0d got %0d want %0d",
                                              want.position, result.element, want.element));
                end
                if (result.last !== want.last)
                begin
                    report_mismatch($sformatf("last at pos %0d got %b want %b",
                                              want.position, result.last, want.last));
                end
                if (result.advanced !== want.advanced)
                begin
                    report_mismatch($sformatf("advanced at pos %0d got %b want %b",
                                              want.position, result.advanced, want.advanced));
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_lexicographic_permutation_step failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int alphabet;
        int steps;
        int target;
        logic op;

        shadow_len = lps_pkg::LENGTH_RESET;
        for (int i = 0; i < lps_pkg::MAX_LENGTH; i++)
        begin
            shadow_arr[i] = '0;
        end

        // directed table
        // strictly falling fill: index and value extremes, every position loaded once
        for (int i = 0; i < lps_pkg::MAX_LENGTH; i++)
        begin
            add_row(1'b0, 0, make_item(lps_pkg::OP_LOAD, i, 255 - 17 * i), 1'b0);
        end
        // reset length of 16 on a falling arrangement: already the last one
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b1);
        // length one never has a pivot, one element with last set
        add_row(1'b1, 1, '0, 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 15, 255), 1'b1);
        // length zero acts as one
        add_row(1'b1, 0, '0, 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b1);
        // two equal values: no ascent, stays put
        add_row(1'b1, 2, '0, 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_LOAD, 1, 255), 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b1);
        // an ascent at the front swaps the pair
        add_row(1'b0, 0, make_item(lps_pkg::OP_LOAD, 0, 0), 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b0);
        // length beyond the store saturates to the full arrangement
        add_row(1'b1, 31, '0, 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b0);
        add_row(1'b1, 16, '0, 1'b0);
        add_row(1'b0, 0, make_item(lps_pkg::OP_ADVANCE, 0, 0), 1'b0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                set_length(directed[i].len);
            end
            else
            begin
                send_item(directed[i].it, directed[i].held);
            end
        end

        // random phases: pick a length, load every position in use, then walk
        // through successors with a few stray transfers mixed in
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            set_length(lps_pkg::LEN_W'(pick_length()));
            n = active_count();
            alphabet = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
            begin
                send_item(make_item(lps_pkg::OP_LOAD, i, draw_value(alphabet, n)), 1'b0);
            end
            steps = $urandom_range(2, 9);
            for (int s = 0; s < steps; s++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    // stray transfer: any operation, any position, any value
                    op = 1'($urandom_range(0, 1));
                    send_item(make_item(op, $urandom_range(0, 15), $urandom_range(0, 255)),
                              1'b0);
                end
                send_item(make_item(lps_pkg::OP_ADVANCE, $urandom_range(0, 15),
                                    $urandom_range(0, 255)), 1'b0);
            end
        end

        // drain, then let the block settle before the verdict
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (HOLD_OFF) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("run: %0d transfers in (%0d loads, %0d advances, %0d at the last arrangement)",
                 items_sent, loads_sent, advances_sent, final_hits);
        $display("run: %0d results checked over %0d length settings, %0d mismatches",
                 results_seen, length_writes, mismatches);
        if (mismatches == 0)
        begin
            $display("tb_lexicographic_permutation_step passed");
        end
        else
        begin
            $display("tb_lexicographic_permutation_step failed");
        end
        $finish;
    end

endmodule
